@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Request and status codes shared by the deque block.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DATA_W  = 32;
   localparam int TOTAL_W = 5;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_DELETE     = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;
   localparam logic [2:0] OP_SIZE       = 3'd6;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

@@ rtl/deq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/integer_deque_with_value_delete.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_deque_with_value_delete
// Bounded double-ended queue of signed 32-bit values held in a circular
// entry store, with delete of the first matching value.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for one cycle with rsp_valid and cannot be held
// off. Push, clear, size query and rejected requests answer in the next
// cycle and busy stays low, so these run at one request per cycle. A pop
// reads the store and answers from the registered read data in S_POP. A
// delete walks the store through its single read port, one entry per cycle,
// and then moves each later entry one place towards the front, so it reads
// every held entry whatever the match position. No clearing pass.
// ----------------------------------------------------------------------------
module integer_deque_with_value_delete #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_data_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_popped_value,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_entry_total
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_POP   = 4'b0010,
      S_SCAN  = 4'b0100,
      S_SHIFT = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        front_ff, front_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [31:0]          val_ff, val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_popped_ff, rsp_popped_in;
   deq_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                 wr_en, rd_en;
   logic [IW-1:0]        wr_addr, rd_addr;
   logic [31:0]          wr_data, rd_data;
   logic [CW-1:0]        pos_nx;
   logic                 accept, full, empty;

   function automatic logic [IW-1:0] slot(input logic [IW-1:0] f, input logic [CW-1:0] p);
      logic [SW-1:0] sum;
      sum = SW'(f) + SW'(p);
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return sum[IW-1:0];
   endfunction

   assign accept = start && !busy;
   assign full   = (count_ff == CW'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign pos_nx = pos_ff + CW'(1);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      rsp_valid_in  = 1'b0;
      rsp_popped_in = '0;
      rsp_status_in = deq_pkg::ST_OK;
      wr_en         = 1'b0;
      wr_addr       = slot(front_ff, count_ff);
      wr_data       = req_data_value;
      rd_en         = 1'b0;
      rd_addr       = slot(front_ff, pos_nx);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in = req_data_value;
               case (req_type)
                  deq_pkg::OP_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = deq_pkg::ST_FULL;
                     end else begin
                        front_in = (front_ff == '0) ? IW'(CAPACITY - 1) : front_ff - IW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  deq_pkg::OP_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = deq_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = deq_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = count_ff - CW'(1);
                        state_in = S_POP;
                        if (req_type == deq_pkg::OP_POP_FRONT) begin
                           rd_addr  = front_ff;
                           front_in = (front_ff == IW'(CAPACITY - 1)) ? '0 : front_ff + IW'(1);
                        end else begin
                           rd_addr = slot(front_ff, count_in);
                        end
                     end
                  end
                  deq_pkg::OP_DELETE: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = deq_pkg::ST_NOT_FOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        pos_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  deq_pkg::OP_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     front_in     = '0;
                     count_in     = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_popped_in = rd_data;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            rd_en = (pos_nx < count_ff);
            if (rd_data == val_ff) begin
               if (pos_nx < count_ff) begin
                  pos_in   = pos_nx;
                  state_in = S_SHIFT;
               end else begin
                  count_in     = count_ff - CW'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (pos_nx < count_ff) begin
               pos_in = pos_nx;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = deq_pkg::ST_NOT_FOUND;
               state_in      = S_IDLE;
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = slot(front_ff, pos_ff - CW'(1));
            wr_data = rd_data;
            rd_en   = (pos_nx < count_ff);
            if (pos_nx < count_ff) begin
               pos_in = pos_nx;
            end else begin
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
   end

   deq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (deq_pkg::DATA_W),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_total  = deq_pkg::TOTAL_W'(count_ff);

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_pop_answers : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |=> rsp_valid && state_ff == S_IDLE)
      else $error("pop did not answer in the following cycle");

   a_clear : assert property (@(posedge clock) disable iff (reset)
      accept && req_type == deq_pkg::OP_CLEAR |=> rsp_valid && count_ff == '0)
      else $error("clear left entries behind");

   a_shift_window : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> pos_ff != '0 && pos_ff < count_ff)
      else $error("shift position outside occupied window");

   a_busy_no_rsp : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> !rsp_valid)
      else $error("response during delete scan");

endmodule

@@ tb/tb_integer_deque_with_value_delete.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_deque_with_value_delete
// Self-checking bench for the bounded deque with delete by value. Requests
// go in through start/busy and each result is compared with a shadow deque
// updated at every accepted request. Directed corner cases come first, then
// fill/drain rounds, duplicate-heavy deletes and a random mix, each run with
// the sender idling at several rates.
// ----------------------------------------------------------------------------
module tb_integer_deque_with_value_delete;

   localparam int DEPTH          = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_GAP        = 60;
   localparam int DRAIN_CYCLES   = 40;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

   typedef struct {
      logic signed [31:0]  popped;
      deq_pkg::status_type status;
      logic [4:0]          total;
   } deque_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_type = deq_pkg::OP_SIZE;
   logic signed [31:0] req_data_value = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_popped_value;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_entry_total;

   // shadow deque
   logic signed [31:0] sh_store [DEPTH];
   logic [3:0]         sh_front = '0;
   logic [4:0]         sh_count = '0;

   deque_reply_type deque_replies [$];
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int idle_pct       = 0;
   int requests_by_op [8];
   int status_seen    [4];

   integer_deque_with_value_delete #(.CAPACITY(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_entry_total  (rsp_entry_total)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [3:0] slot_at(input int pos);
      return sh_front + 4'(pos);
   endfunction

   function automatic void predict_deque(input logic [2:0] op,
                                         input logic signed [31:0] val,
                                         output deque_reply_type r);
      int  p;
      int  q;
      bit  found;
      r.popped = '0;
      r.status = deq_pkg::ST_OK;
      found    = 1'b0;
      case (op)
         deq_pkg::OP_PUSH_FRONT: begin
            if (sh_count >= DEPTH) r.status = deq_pkg::ST_FULL;
            else begin
               sh_front           = sh_front - 4'd1;
               sh_store[sh_front] = val;
               sh_count           = sh_count + 5'd1;
            end
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (sh_count >= DEPTH) r.status = deq_pkg::ST_FULL;
            else begin
               sh_store[slot_at(sh_count)] = val;
               sh_count                    = sh_count + 5'd1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (sh_count == 0) r.status = deq_pkg::ST_EMPTY;
            else begin
               r.popped = sh_store[sh_front];
               sh_front = sh_front + 4'd1;
               sh_count = sh_count - 5'd1;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (sh_count == 0) r.status = deq_pkg::ST_EMPTY;
            else begin
               r.popped = sh_store[slot_at(sh_count - 1)];
               sh_count = sh_count - 5'd1;
            end
         end
         deq_pkg::OP_DELETE: begin
            r.status = deq_pkg::ST_NOT_FOUND;
            for (p = 0; p < sh_count && !found; p++) begin
               if (sh_store[slot_at(p)] == val) begin
                  for (q = p; q + 1 < sh_count; q++)
                     sh_store[slot_at(q)] = sh_store[slot_at(q + 1)];
                  sh_count = sh_count - 5'd1;
                  r.status = deq_pkg::ST_OK;
                  found    = 1'b1;
               end
            end
         end
         deq_pkg::OP_CLEAR: begin
            sh_front = '0;
            sh_count = '0;
         end
         default: ;
      endcase
      r.total = sh_count;
   endfunction

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(9))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2, 3, 4: return $signed(32'($urandom_range(7))) - 32'sd3;
         default: return $signed($urandom());
      endcase
   endfunction

   // a value currently held (a random one when empty), so that a delete finds it
   function automatic logic signed [31:0] held_value();
      if (sh_count == 0) return random_value();
      return sh_store[slot_at($urandom_range(sh_count - 1))];
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic sender_pause();
      int n;
      n = 0;
      while (n < MAX_GAP && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         n++;
      end
   endtask

   task automatic send_request(input logic [2:0] op, input logic signed [31:0] val);
      deque_reply_type r;
      sender_pause();
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= op;
      req_data_value <= val;
      do @(posedge clock); while (busy);
      predict_deque(op, val, r);
      deque_replies = {deque_replies, r};
      requests_by_op[op]++;
   endtask

   always @(posedge clock) begin
      deque_reply_type e;
      if (!reset && rsp_valid) begin
         if (deque_replies.size() == 0) begin
            report_mismatch("result with no request outstanding", rsp_status, -1);
         end else begin
            e = deque_replies[0];
            deque_replies.delete(0);
            if (rsp_popped_value !== e.popped)
               report_mismatch("popped value", rsp_popped_value, e.popped);
            if (rsp_status !== e.status)
               report_mismatch("status", rsp_status, e.status);
            if (rsp_entry_total !== e.total)
               report_mismatch("entry total", rsp_entry_total, e.total);
            status_seen[rsp_status]++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic test_directed();
      send_request(deq_pkg::OP_PUSH_FRONT, MOST_NEG);
      send_request(deq_pkg::OP_PUSH_BACK,  MOST_POS);
      send_request(deq_pkg::OP_PUSH_FRONT, 32'sd0);
      send_request(deq_pkg::OP_PUSH_BACK,  -32'sd1);
      send_request(deq_pkg::OP_SIZE,       32'sd5);
      send_request(deq_pkg::OP_DELETE,     -32'sd1);
      send_request(deq_pkg::OP_DELETE,     32'sd12345);
      send_request(deq_pkg::OP_POP_FRONT,  32'sd0);
      send_request(deq_pkg::OP_POP_BACK,   32'sd0);
      send_request(deq_pkg::OP_POP_BACK,   32'sd0);
      send_request(deq_pkg::OP_POP_FRONT,  32'sd0);
      send_request(deq_pkg::OP_POP_BACK,   32'sd0);
      send_request(deq_pkg::OP_DELETE,     MOST_NEG);
      send_request(OP_UNUSED,              MOST_POS);
      send_request(deq_pkg::OP_PUSH_BACK,  32'sd7);
      send_request(deq_pkg::OP_PUSH_BACK,  32'sd7);
      send_request(deq_pkg::OP_DELETE,     32'sd7);
      send_request(deq_pkg::OP_CLEAR,      32'sd0);
      send_request(deq_pkg::OP_SIZE,       32'sd0);
      send_request(deq_pkg::OP_POP_FRONT,  32'sd0);
   endtask

   // fill past capacity, then drain past empty
   task automatic test_fill_and_drain(input int rounds);
      int k;
      for (int r = 0; r < rounds; r++) begin
         while (sh_count < DEPTH) begin
            k = $urandom_range(9);
            if (k < 4)       send_request(deq_pkg::OP_PUSH_FRONT, random_value());
            else if (k < 8)  send_request(deq_pkg::OP_PUSH_BACK, random_value());
            else if (k == 8) send_request(deq_pkg::OP_DELETE, held_value());
            else             send_request(deq_pkg::OP_SIZE, random_value());
         end
         send_request(deq_pkg::OP_PUSH_FRONT, random_value());
         send_request(deq_pkg::OP_PUSH_BACK, random_value());
         send_request(deq_pkg::OP_DELETE, held_value());
         while (sh_count > 0) begin
            k = $urandom_range(9);
            if (k < 4)       send_request(deq_pkg::OP_POP_FRONT, random_value());
            else if (k < 8)  send_request(deq_pkg::OP_POP_BACK, random_value());
            else if (k == 8) send_request(deq_pkg::OP_DELETE, held_value());
            else if (r % 2 == 1 && sh_count < 8)
               send_request(deq_pkg::OP_CLEAR, random_value());
            else             send_request(deq_pkg::OP_DELETE, random_value());
         end
         send_request($urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                      random_value());
         send_request(deq_pkg::OP_DELETE, random_value());
      end
   endtask

   // narrow value pool so that duplicates are common
   task automatic test_delete_heavy(input int n);
      int k;
      logic signed [31:0] v;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         v = $signed(32'($urandom_range(3)));
         if (sh_count < 6 && k < 70)
            send_request(k[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK, v);
         else if (sh_count > 13 && k < 60)
            send_request(deq_pkg::OP_DELETE, v);
         else if (k < 40)
            send_request(k[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK, v);
         else if (k < 85)
            send_request(deq_pkg::OP_DELETE, v);
         else if (k < 95)
            send_request(k[0] ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK, v);
         else
            send_request(deq_pkg::OP_SIZE, v);
      end
   endtask

   task automatic test_random_mix(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 22)      send_request(deq_pkg::OP_PUSH_FRONT, random_value());
         else if (k < 44) send_request(deq_pkg::OP_PUSH_BACK, random_value());
         else if (k < 56) send_request(deq_pkg::OP_POP_FRONT, random_value());
         else if (k < 68) send_request(deq_pkg::OP_POP_BACK, random_value());
         else if (k < 77) send_request(deq_pkg::OP_DELETE, held_value());
         else if (k < 86) send_request(deq_pkg::OP_DELETE, random_value());
         else if (k < 97) send_request(deq_pkg::OP_SIZE, random_value());
         else             send_request(deq_pkg::OP_CLEAR, random_value());
      end
   endtask

   initial begin
      int idle_phases [3];
      idle_phases = '{0, 81, 33};
      foreach (sh_store[i]) sh_store[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      foreach (idle_phases[ph]) begin
         idle_pct = idle_phases[ph];
         test_fill_and_drain(4);
         test_delete_heavy(200);
         test_random_mix(270);
      end

      @(negedge clock);
      start <= 1'b0;
      wait (deque_replies.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (deque_replies.size() != 0)
         report_mismatch("results never delivered", 0, deque_replies.size());

      $display("covered: push front %0d, push back %0d, pop front %0d, pop back %0d,",
               requests_by_op[deq_pkg::OP_PUSH_FRONT], requests_by_op[deq_pkg::OP_PUSH_BACK],
               requests_by_op[deq_pkg::OP_POP_FRONT], requests_by_op[deq_pkg::OP_POP_BACK]);
      $display("  delete %0d, clear %0d, size %0d, unused %0d; ok %0d empty %0d full %0d %s %0d",
               requests_by_op[deq_pkg::OP_DELETE], requests_by_op[deq_pkg::OP_CLEAR],
               requests_by_op[deq_pkg::OP_SIZE], requests_by_op[OP_UNUSED],
               status_seen[deq_pkg::ST_OK], status_seen[deq_pkg::ST_EMPTY],
               status_seen[deq_pkg::ST_FULL], "not found", status_seen[deq_pkg::ST_NOT_FOUND]);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
